// ----- sv/alignment_column_distinct_letters_macros.svh -----
// Assertion macros shared by the RTL of the column letter counter.
// Depends on nothing; the asserting module supplies i_clk and i_rst_n.
`ifndef ALIGNMENT_COLUMN_DISTINCT_LETTERS_MACROS_SVH
`define ALIGNMENT_COLUMN_DISTINCT_LETTERS_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only out of reset.
`define ACDL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ACDL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ACDL_ASSERT(lbl, prop, msg)
`define ACDL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/acdl_pkg.sv -----
// Shared types and constants of the column letter counter.
// No dependencies; used by the output queue, the top level and the testbench.
`default_nettype none

package acdl_pkg;

    localparam int MAX_COLUMNS  = 16384;
    localparam int COL_W        = $clog2(MAX_COLUMNS);
    localparam int LETTER_COUNT = 26;
    localparam int CNT_W        = 5;
    localparam int DIGIT_W      = 7;
    localparam int LEN_W        = 15;

    // Output queue
    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = 1;
    localparam int OB_CNT_W = 2;

    // Item modes
    localparam logic [1:0] MODE_ACCUM = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Register indexes
    localparam logic CFG_PROTEIN_MODE = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic [LEN_W-1:0] COLUMN_COUNT_RST = 15'd16384;

    // ASCII codes
    localparam logic [7:0] CH_UA = 8'h41;  // 'A'
    localparam logic [7:0] CH_UZ = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LA = 8'h61;  // 'a'
    localparam logic [7:0] CH_LZ = 8'h7A;  // 'z'
    localparam logic [7:0] CH_UB = 8'h42;
    localparam logic [7:0] CH_UC = 8'h43;
    localparam logic [7:0] CH_UG = 8'h47;
    localparam logic [7:0] CH_UJ = 8'h4A;
    localparam logic [7:0] CH_UO = 8'h4F;
    localparam logic [7:0] CH_UT = 8'h54;
    localparam logic [7:0] CH_UU = 8'h55;
    localparam logic [DIGIT_W-1:0] CH_ZERO = 7'h30;
    localparam logic [DIGIT_W-1:0] CH_TEN  = 7'h37;  // 'A' - 10

    localparam logic [CNT_W-1:0] DIGIT_SPLIT = 5'd10;

    typedef struct packed {
        logic [1:0]       mode;
        logic [COL_W-1:0] column;
        logic [7:0]       char_code;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]   out_column;
        logic [CNT_W-1:0]   distinct_count;
        logic [DIGIT_W-1:0] digit_char;
    } t_out_item;

    // Queue status seen by the issue logic
    typedef struct packed {
        logic [OB_CNT_W-1:0] count;
        logic                pop;
    } t_ob_status;

endpackage

`default_nettype wire

// ----- sv/acdl_out_fifo.sv -----
// Two-entry result queue between the read stage and the output channel.
// Depends on acdl_pkg for the result type and queue sizes.
`default_nettype none

module acdl_out_fifo
    import acdl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_out_item  i_push_item,
    output t_ob_status      o_status,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_item
);

    t_out_item           r_slot [OB_DEPTH];
    logic [OB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OB_CNT_W-1:0] r_count, n_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_slot[r_rd_ptr];

    assign o_status.count = r_count;
    assign o_status.pop   = pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr + OB_PTR_W'(i_push);
        n_rd_ptr = r_rd_ptr + OB_PTR_W'(pop);
        n_count  = r_count + OB_CNT_W'(i_push) - OB_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/alignment_column_distinct_letters.sv -----
// Channel  | dir | handshake                | beat
// ---------+-----+--------------------------+---------------------------------
// in       | in  | i_in_valid / o_in_ready   | t_in_item: mode, column, char
// out      | out | o_out_valid / i_out_ready | t_out_item: column, count, digit
// cfg      | in  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item per cycle unless stalled; reads leave via the modify stage and queue.
// Masks sit in a 16384 x 26 single-write RAM with a registered read; the
// read-modify-write stage forwards the previous write to the next item.
// After reset a clearing pass zeroes all 16384 RAM addresses; no input beat
// is taken until it ends (configuration writes are taken throughout).
// Otherwise input stalls only while the two-entry result queue could overflow.
//
// Depends on acdl_pkg, acdl_out_fifo and the assertion macro header.
`default_nettype none
`include "alignment_column_distinct_letters_macros.svh"

module alignment_column_distinct_letters
    import acdl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out
);

    function automatic logic [2:0] f_nibble_count(input logic [3:0] v);
        return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    endfunction

    function automatic logic [CNT_W-1:0] f_popcount(input logic [LETTER_COUNT-1:0] m);
        logic [27:0]      w;
        logic [CNT_W-1:0] n;
        w = {2'b00, m};
        n = '0;
        for (int g = 0; g < 7; g++) begin
            n = n + CNT_W'(f_nibble_count(w[g*4 +: 4]));
        end
        return n;
    endfunction

    function automatic logic f_allowed(input logic protein, input logic [7:0] up);
        logic amino;
        logic nucl;
        amino = !(up == CH_UB || up == CH_UJ || up == CH_UO || up == CH_UU || up == CH_UZ);
        nucl  = (up == CH_UA || up == CH_UC || up == CH_UG || up == CH_UT || up == CH_UU);
        return protein ? amino : nucl;
    endfunction

    // Configuration
    logic             r_protein_mode;
    logic [LEN_W-1:0] r_column_count;

    // Clearing pass
    logic             r_clr_busy, n_clr_busy;
    logic [COL_W-1:0] r_clr_addr, n_clr_addr;

    // Mask RAM
    logic [LETTER_COUNT-1:0] r_mem [MAX_COLUMNS];
    logic [LETTER_COUNT-1:0] r_rd_data;
    logic                    mem_we;
    logic [COL_W-1:0]        mem_wa;
    logic [LETTER_COUNT-1:0] mem_wd;

    // Read-modify-write stage
    logic                    r_s1_valid;
    logic [1:0]              r_s1_mode;
    logic [COL_W-1:0]        r_s1_col;
    logic [LETTER_COUNT-1:0] r_s1_set;
    logic [LETTER_COUNT-1:0] s1_old;
    logic [LETTER_COUNT-1:0] s1_new;
    logic                    s1_wr;
    logic                    s1_push;
    logic [CNT_W-1:0]        s1_count;
    t_out_item               s1_item;

    // Last write, for the item one behind
    logic                    r_fwd_valid;
    logic [COL_W-1:0]        r_fwd_col;
    logic [LETTER_COUNT-1:0] r_fwd_mask;

    // Issue
    logic                    in_acc;
    logic                    in_range;
    logic                    is_lower;
    logic                    is_upper;
    logic [7:0]              letter_off;
    logic [7:0]              upper_code;
    logic [LETTER_COUNT-1:0] in_set;
    logic [OB_CNT_W:0]       ob_next;
    t_ob_status              ob_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protein_mode <= 1'b0;
            r_column_count <= COLUMN_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROTEIN_MODE: r_protein_mode <= i_cfg_data[0];
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + COL_W'(1);
            if (r_clr_addr == COL_W'(MAX_COLUMNS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Hold the input while the queue could be full when this item's result lands
    assign ob_next    = {1'b0, ob_status.count} + (OB_CNT_W+1)'(s1_push)
                        - (OB_CNT_W+1)'(ob_status.pop);
    assign o_in_ready = !r_clr_busy && (ob_next < (OB_CNT_W+1)'(OB_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;

    // Letter decode at issue
    always_comb begin
        in_range   = {1'b0, i_in.column} < r_column_count;
        is_lower   = (i_in.char_code >= CH_LA) && (i_in.char_code <= CH_LZ);
        is_upper   = (i_in.char_code >= CH_UA) && (i_in.char_code <= CH_UZ);
        letter_off = i_in.char_code - (is_lower ? CH_LA : CH_UA);
        upper_code = CH_UA + letter_off;
        in_set     = '0;
        if (i_in.mode == MODE_ACCUM && in_range && (is_lower || is_upper)
            && f_allowed(r_protein_mode, upper_code)) begin
            in_set = LETTER_COUNT'(1) << letter_off[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode <= i_in.mode;
            r_s1_col  <= i_in.column;
            r_s1_set  <= in_set;
        end
    end

    // Modify: take the previous write when it hit the same column
    always_comb begin
        s1_old  = (r_fwd_valid && r_fwd_col == r_s1_col) ? r_fwd_mask : r_rd_data;
        s1_wr   = 1'b0;
        s1_push = 1'b0;
        s1_new  = s1_old | r_s1_set;
        unique case (r_s1_mode)
            MODE_ACCUM: s1_wr = r_s1_valid;
            MODE_READ:  s1_push = r_s1_valid;
            MODE_CLEAR: begin
                s1_wr  = r_s1_valid;
                s1_new = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        s1_count                = f_popcount(s1_old);
        s1_item.out_column      = r_s1_col;
        s1_item.distinct_count  = s1_count;
        s1_item.digit_char      = (s1_count < DIGIT_SPLIT)
                                  ? CH_ZERO + DIGIT_W'(s1_count)
                                  : CH_TEN + DIGIT_W'(s1_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_fwd_col  <= r_s1_col;
            r_fwd_mask <= s1_new;
        end
    end

    // Single write port: clearing pass or the modify stage
    assign mem_we = r_clr_busy || s1_wr;
    assign mem_wa = r_clr_busy ? r_clr_addr : r_s1_col;
    assign mem_wd = r_clr_busy ? '0 : s1_new;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_in.column];
    end

    acdl_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s1_push),
        .i_push_item (s1_item),
        .o_status    (ob_status),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out)
    );

    `ACDL_ASSERT_ALWAYS(a_no_issue_while_clearing, r_clr_busy |-> !o_in_ready, "beat taken during clearing pass")
    `ACDL_ASSERT(a_port_free_while_clearing, r_clr_busy |-> !r_s1_valid, "modify stage active during clearing pass")
    `ACDL_ASSERT(a_queue_no_overflow, s1_push |-> (ob_status.count < OB_CNT_W'(OB_DEPTH) || ob_status.pop), "result queue overflow")
    `ACDL_ASSERT(a_fwd_follows_write, r_fwd_valid |-> $past(r_s1_valid), "forward entry without a write")

endmodule

`default_nettype wire

// ----- tb/tb_alignment_column_distinct_letters.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the per-column distinct letter counter.
// Depends on acdl_pkg and the alignment_column_distinct_letters top level;
// a scoreboard class tracks the column masks and the reads still in flight.

module tb_alignment_column_distinct_letters;
    import acdl_pkg::*;

    localparam logic [1:0] MODE_NONE   = 2'd3;  // unused mode, block ignores it
    localparam int         STALL_LIMIT = 50000; // covers the clearing pass after reset
    localparam int         LONG_HOLD   = 300;
    localparam int         DRAIN_CYCLES = 6;
    localparam int         MAX_REPORTS = 10;

    class letter_mask_scoreboard;
        bit [LETTER_COUNT-1:0] masks [MAX_COLUMNS];
        bit                    protein;
        bit [LEN_W-1:0]        col_limit;
        t_out_item             pending_counts [$];
        int                    errors;

        function new();
            protein   = 1'b0;
            col_limit = COLUMN_COUNT_RST;
            errors    = 0;
        endfunction

        function void set_register(logic idx, logic [LEN_W-1:0] value);
            if (idx == CFG_PROTEIN_MODE) begin
                protein = value[0];
            end else begin
                col_limit = value;
            end
        endfunction

        function bit letter_allowed(int idx);
            logic [7:0] up;
            up = CH_UA + 8'(idx);
            if (protein) begin
                return !(up == CH_UB || up == CH_UJ || up == CH_UO || up == CH_UU || up == CH_UZ);
            end
            return up == CH_UA || up == CH_UC || up == CH_UG || up == CH_UT || up == CH_UU;
        endfunction

        // Apply one accepted input beat to the masks; queue the result of a read.
        function void note_item(t_in_item it);
            int        idx;
            int        n;
            t_out_item r;
            case (it.mode)
                MODE_ACCUM: begin
                    idx = -1;
                    if (it.char_code >= CH_LA && it.char_code <= CH_LZ) begin
                        idx = it.char_code - CH_LA;
                    end else if (it.char_code >= CH_UA && it.char_code <= CH_UZ) begin
                        idx = it.char_code - CH_UA;
                    end
                    if ({1'b0, it.column} < col_limit && idx >= 0 && letter_allowed(idx)) begin
                        masks[it.column][idx] = 1'b1;
                    end
                end
                MODE_READ: begin
                    n = $countones(masks[it.column]);
                    r.out_column     = it.column;
                    r.distinct_count = CNT_W'(n);
                    r.digit_char     = (n < DIGIT_SPLIT) ? CH_ZERO + DIGIT_W'(n)
                                                         : CH_TEN + DIGIT_W'(n);
                    pending_counts.push_back(r);
                end
                MODE_CLEAR: begin
                    masks[it.column] = '0;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_count(t_out_item got);
            t_out_item want;
            if (pending_counts.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result beat: col %0d count %0d digit %0d",
                             got.out_column, got.distinct_count, got.digit_char);
                end
                return;
            end
            want = pending_counts.pop_front();
            if (got.out_column !== want.out_column
                    || got.distinct_count !== want.distinct_count
                    || got.digit_char !== want.digit_char) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch: expected col %0d count %0d digit %0d",
                             want.out_column, want.distinct_count, want.digit_char);
                    $display("          actual   col %0d count %0d digit %0d",
                             got.out_column, got.distinct_count, got.digit_char);
                end
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_PROTEIN_MODE;
    logic [LEN_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_beat   = '0;
    logic             out_valid;
    logic             out_ready = 1'b1;
    t_out_item        out_beat;

    letter_mask_scoreboard scoreboard = new();
    bit quiet         = 1'b0;
    bit hold_out_req  = 1'b0;

    alignment_column_distinct_letters u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check each accepted beat, stall in random bursts or one long hold.
    initial begin : result_sink
        int idle_left;
        bit hold_taken;
        idle_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_valid === 1'b1 && out_ready) begin
                scoreboard.check_count(out_beat);
            end
            if (idle_left > 0) begin
                idle_left--;
            end else if (hold_out_req && !hold_taken) begin
                hold_taken = 1'b1;
                idle_left  = LONG_HOLD;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(1, 17);
            end
            out_ready <= (idle_left == 0);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    function automatic t_in_item make_item(logic [1:0] mode, int col, int ch);
        t_in_item it;
        it.mode      = mode;
        it.column    = COL_W'(col);
        it.char_code = 8'(ch);
        return it;
    endfunction

    // Mostly letters on a few hot columns so the masks fill up; the rest is noise.
    function automatic t_in_item random_item(logic [LEN_W-1:0] limit);
        t_in_item it;
        int       pick;
        int       boundary;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            it.mode = MODE_ACCUM;
        end else if (pick < 88) begin
            it.mode = MODE_READ;
        end else if (pick < 95) begin
            it.mode = MODE_CLEAR;
        end else begin
            it.mode = MODE_NONE;
        end
        boundary = (limit == 0) ? 0 : int'(limit) - 1;
        if (boundary > MAX_COLUMNS - 1) begin
            boundary = MAX_COLUMNS - 1;
        end
        case ($urandom_range(0, 7))
            0: it.column = '0;
            1: it.column = COL_W'(MAX_COLUMNS - 1);
            2: it.column = COL_W'(boundary);
            3: it.column = COL_W'((boundary + 1 > MAX_COLUMNS - 1) ? boundary : boundary + 1);
            4: it.column = COL_W'(1);
            5: it.column = COL_W'(MAX_COLUMNS / 2 - 1);
            default: it.column = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
        endcase
        if ($urandom_range(0, 3) != 0) begin
            it.char_code = CH_UA + 8'($urandom_range(0, LETTER_COUNT - 1));
            if ($urandom_range(0, 1) == 1) begin
                it.char_code = it.char_code + (CH_LA - CH_UA);
            end
        end else begin
            it.char_code = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= it;
        @(posedge i_clk);
        while (in_ready !== 1'b1) @(posedge i_clk);
        scoreboard.note_item(it);
    endtask

    // Hold input until every read has come back and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input bit protein, input logic [LEN_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PROTEIN_MODE;
        cfg_data  <= {{(LEN_W-1){1'b0}}, protein};
        @(posedge i_clk);
        cfg_index <= CFG_COLUMN_COUNT;
        cfg_data  <= limit;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        scoreboard.set_register(CFG_PROTEIN_MODE, {{(LEN_W-1){1'b0}}, protein});
        scoreboard.set_register(CFG_COLUMN_COUNT, limit);
    endtask

    task automatic run_random(input int count, input logic [LEN_W-1:0] limit);
        repeat (count) send_item(random_item(limit));
    endtask

    task automatic run_directed();
        send_item(make_item(MODE_CLEAR, 0, 0));
        send_item(make_item(MODE_CLEAR, MAX_COLUMNS - 1, 0));
        send_item(make_item(MODE_ACCUM, 0, CH_LA));
        send_item(make_item(MODE_ACCUM, 0, CH_LZ));
        send_item(make_item(MODE_ACCUM, 0, CH_UB));
        send_item(make_item(MODE_ACCUM, 0, CH_UJ));
        send_item(make_item(MODE_ACCUM, 0, CH_UO));
        send_item(make_item(MODE_ACCUM, 0, CH_UU));
        send_item(make_item(MODE_ACCUM, 0, CH_UA));
        send_item(make_item(MODE_ACCUM, 0, CH_UZ - 1));
        // bytes just outside the letter ranges, plus high-bit bytes
        send_item(make_item(MODE_ACCUM, 0, CH_UA - 1));
        send_item(make_item(MODE_ACCUM, 0, CH_UZ + 1));
        send_item(make_item(MODE_ACCUM, 0, CH_LA - 1));
        send_item(make_item(MODE_ACCUM, 0, CH_LZ + 1));
        send_item(make_item(MODE_ACCUM, 0, 8'h00));
        send_item(make_item(MODE_ACCUM, 0, 8'hFF));
        send_item(make_item(MODE_ACCUM, 0, 8'h80 | CH_UC));
        send_item(make_item(MODE_NONE, 0, CH_UC));
        send_item(make_item(MODE_READ, 0, 0));
        send_item(make_item(MODE_ACCUM, MAX_COLUMNS - 1, CH_LA + 12));
        send_item(make_item(MODE_READ, MAX_COLUMNS - 1, 8'hFF));
        send_item(make_item(MODE_READ, 5, 0));
        send_item(make_item(MODE_CLEAR, 0, 0));
        send_item(make_item(MODE_READ, 0, 0));
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] limit;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings may be written during the clearing pass.
        apply_settings(1'b1, COLUMN_COUNT_RST);
        run_directed();
        drain();

        apply_settings(1'b0, COLUMN_COUNT_RST);
        run_random(90, COLUMN_COUNT_RST);
        drain();

        // Long result stall while beats keep coming: the block must stop taking input.
        limit = LEN_W'($urandom_range(1, MAX_COLUMNS - 1));
        apply_settings(1'b1, limit);
        hold_out_req = 1'b1;
        run_random(90, limit);
        drain();

        // Zero length: every accumulate drops, reads still see old masks.
        apply_settings(1'b1, '0);
        run_random(60, '0);
        drain();

        limit = LEN_W'($urandom_range(2, 200));
        apply_settings(1'b0, limit);
        run_random(90, limit);
        drain();

        quiet = 1'b1;
        apply_settings(1'b1, COLUMN_COUNT_RST);
        run_random(90, COLUMN_COUNT_RST);
        drain();

        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
